>>> rtl/fhtlv_pkg.sv
`timescale 1ns / 1ps
package fhtlv_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_TLV    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_VERSION = 2'd2;
	localparam logic [1:0] ST_BOUNDS  = 2'd3;

	localparam logic [2:0] REG_MAGIC     = 3'd0;
	localparam logic [2:0] REG_MAJOR     = 3'd1;
	localparam logic [2:0] REG_MAX_MINOR = 3'd2;
	localparam logic [2:0] REG_FLAG_MASK = 3'd3;
	localparam logic [2:0] REG_TYPE_LOW  = 3'd4;
	localparam logic [2:0] REG_TYPE_HIGH = 3'd5;

	localparam int unsigned HEAD_BYTES = 32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [1:0]  status;
		logic [15:0] major_ver;
		logic [15:0] minor_ver;
		logic [15:0] type_code;
		logic [63:0] corr_id;
		logic [15:0] length_value;
		logic [15:0] value_offset;
		logic        known_type;
		logic        required_bit;
		logic        last_result;
	} out_item_t;

	// What the parser hands to the result queue for one accepted byte.
	typedef struct packed {
		logic      first_valid;
		out_item_t first;
		logic      second_valid;
		out_item_t second;
	} pair_t;

endpackage

>>> rtl/fhtlv_parser.sv
`timescale 1ns / 1ps
module fhtlv_parser #(
	parameter int unsigned MAX_FRAME_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  fhtlv_pkg::in_item_t item,
	input  logic [31:0]         magic_word,
	input  logic [15:0]         req_major,
	input  logic [15:0]         max_minor_version,
	input  logic [15:0]         required_flag_mask,
	input  logic [15:0]         known_type_low,
	input  logic [15:0]         known_type_high,
	output fhtlv_pkg::pair_t    pair
);
	localparam logic [31:0] PAY_LIMIT = (MAX_FRAME_BYTES > 32) ?
		32'(MAX_FRAME_BYTES - 32) : 32'd0;

	typedef enum logic [3:0] {
		PH_HEAD  = 4'b0001,
		PH_TLVH  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_PAD   = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [16:0] count_q, count_d;
	logic [63:0] shift_q, shift_d;
	logic [31:0] pay_len_q, pay_len_d;
	logic [2:0]  hc_q, hc_d;
	logic [15:0] ttype_q, ttype_d, tflag_q, tflag_d;
	logic [31:0] vleft_q, vleft_d, tlen_q, tlen_d;
	logic [1:0]  pad_q, pad_d, err_q, err_d;
	logic [15:0] hmaj_q, hmaj_d, hmin_q, hmin_d, htype_q, htype_d;
	logic [63:0] hcorr_q, hcorr_d;
	// Payload offset of the current byte, and payload bytes left after it.
	logic [31:0] off, rem_after;
	logic [32:0] need;
	logic [7:0]  b;
	logic [63:0] sh_in;
	fhtlv_pkg::out_item_t it0, tlv_it, st_it;
	logic        it0_v;
	logic        fin;
	logic [31:0] fin_end;
	logic [15:0] mask;
	logic        known, req;
	logic [1:0]  npad;

	assign b = item.data_byte;
	assign sh_in = {shift_q[55:0], b};
	assign off = 32'(count_q) - 32'(fhtlv_pkg::HEAD_BYTES);
	assign rem_after = pay_len_q - (off + 32'd1);
	assign mask = required_flag_mask;
	assign npad = 2'(3'd4 - {1'b0, sh_in[1:0]});
	assign need = {1'b0, sh_in[31:0]} + 33'(npad);

	always_comb begin
		phase_d = phase_q; count_d = count_q; shift_d = shift_q; pay_len_d = pay_len_q;
		hc_d = hc_q; ttype_d = ttype_q; tflag_d = tflag_q; vleft_d = vleft_q;
		tlen_d = tlen_q; pad_d = pad_q; err_d = err_q; hmaj_d = hmaj_q;
		hmin_d = hmin_q; htype_d = htype_q; hcorr_d = hcorr_q;
		it0 = '0; it0_v = 1'b0; fin = 1'b0; fin_end = '0;
		tlv_it = '0; st_it = '0;
		known = 1'b0; req = 1'b0;
		if (err_q == fhtlv_pkg::ST_OK) begin
			if (phase_q == PH_HEAD) begin
				shift_d = sh_in;
				count_d = count_q + 17'd1;
				case (count_q[4:0])
					5'd3: if (sh_in[31:0] != magic_word) err_d = fhtlv_pkg::ST_INVALID;
					5'd5: hmaj_d = sh_in[15:0];
					5'd7: begin
						hmin_d = sh_in[15:0];
						if (hmaj_q != req_major || sh_in[15:0] > max_minor_version)
							err_d = fhtlv_pkg::ST_VERSION;
					end
					5'd9: htype_d = sh_in[15:0];
					5'd11: if (sh_in[15:0] != 16'd0) err_d = fhtlv_pkg::ST_INVALID;
					5'd15: if (sh_in[31:0] != 32'(fhtlv_pkg::HEAD_BYTES))
						err_d = fhtlv_pkg::ST_INVALID;
					5'd23: begin
						hcorr_d = sh_in;
						if (sh_in == 64'd0) err_d = fhtlv_pkg::ST_INVALID;
					end
					5'd27: pay_len_d = sh_in[31:0];
					5'd31: begin
						if (sh_in[31:0] != 32'd0) err_d = fhtlv_pkg::ST_INVALID;
						else if (pay_len_q > PAY_LIMIT) err_d = fhtlv_pkg::ST_BOUNDS;
						else begin
							it0_v = 1'b1;
							it0.item_kind = fhtlv_pkg::KIND_HEADER;
							it0.major_ver = hmaj_q;
							it0.minor_ver = hmin_q;
							it0.type_code = htype_q;
							it0.corr_id = hcorr_q;
							it0.length_value = pay_len_q[15:0];
							phase_d = PH_TLVH;
							hc_d = 3'd0;
						end
					end
					default: ;
				endcase
			end else if (off >= pay_len_q) begin
				err_d = fhtlv_pkg::ST_BOUNDS;
			end else begin
				count_d = count_q + 17'd1;
				case (phase_q)
					PH_TLVH: begin
						if (hc_q == 3'd0 && (pay_len_q - off) < 32'd8) begin
							err_d = fhtlv_pkg::ST_BOUNDS;
							count_d = count_q + 17'd1;
						end else begin
							shift_d = sh_in;
							if (hc_q == 3'd1) ttype_d = sh_in[15:0];
							if (hc_q == 3'd3) tflag_d = sh_in[15:0];
							if (hc_q != 3'd7) hc_d = hc_q + 3'd1;
							else begin
								hc_d = 3'd0;
								tlen_d = sh_in[31:0];
								pad_d = npad;
								if (need > {1'b0, rem_after}) err_d = fhtlv_pkg::ST_BOUNDS;
								else begin
									vleft_d = sh_in[31:0];
									if (sh_in[31:0] != 32'd0) phase_d = PH_VALUE;
									else if (npad != 2'd0) phase_d = PH_PAD;
									else fin = 1'b1;
								end
							end
						end
					end
					PH_VALUE: begin
						vleft_d = vleft_q - 32'd1;
						if (vleft_q == 32'd1) begin
							if (pad_q != 2'd0) phase_d = PH_PAD;
							else fin = 1'b1;
						end
					end
					PH_PAD: begin
						if (b != 8'd0) err_d = fhtlv_pkg::ST_INVALID;
						else begin
							pad_d = pad_q - 2'd1;
							if (pad_q == 2'd1) fin = 1'b1;
						end
					end
					default: ;
				endcase
				fin_end = off + 32'd1;
			end
		end
		if (fin) begin
			phase_d = PH_TLVH;
			known = (ttype_d >= known_type_low) && (ttype_d <= known_type_high);
			req = (tflag_d & mask) != 16'd0;
			if ((tflag_d & ~mask) != 16'd0) err_d = fhtlv_pkg::ST_INVALID;
			else if (!known && req) err_d = fhtlv_pkg::ST_VERSION;
			else begin
				it0_v = 1'b1;
				tlv_it.item_kind = fhtlv_pkg::KIND_TLV;
				tlv_it.type_code = ttype_d;
				tlv_it.length_value = tlen_d[15:0];
				tlv_it.value_offset = 16'(fin_end - tlen_d -
					32'(2'(3'd4 - {1'b0, tlen_d[1:0]})));
				tlv_it.known_type = known;
				tlv_it.required_bit = req;
				it0 = tlv_it;
			end
		end
		if (item.end_of_frame) begin
			st_it.item_kind = fhtlv_pkg::KIND_STATUS;
			st_it.last_result = 1'b1;
			st_it.status = err_d;
			if (err_d == fhtlv_pkg::ST_OK) begin
				if (count_d < 17'(fhtlv_pkg::HEAD_BYTES)) st_it.status = fhtlv_pkg::ST_INVALID;
				else if (32'(count_d) - 32'(fhtlv_pkg::HEAD_BYTES) != pay_len_d)
					st_it.status = fhtlv_pkg::ST_BOUNDS;
			end
		end
	end

	// pad_d is zero at finish time for a pad-phase end, so the padding is recomputed above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD; count_q <= '0; shift_q <= '0; pay_len_q <= '0;
			hc_q <= '0; ttype_q <= '0; tflag_q <= '0; vleft_q <= '0; tlen_q <= '0;
			pad_q <= '0; err_q <= fhtlv_pkg::ST_OK; hmaj_q <= '0; hmin_q <= '0;
			htype_q <= '0; hcorr_q <= '0;
			pair <= '0;
		end else begin
			if (take) begin
				if (item.end_of_frame) begin
					phase_q <= PH_HEAD; count_q <= '0; shift_q <= '0; pay_len_q <= '0;
					hc_q <= '0; ttype_q <= '0; tflag_q <= '0; vleft_q <= '0;
					tlen_q <= '0; pad_q <= '0; err_q <= fhtlv_pkg::ST_OK;
					hmaj_q <= '0; hmin_q <= '0; htype_q <= '0; hcorr_q <= '0;
				end else begin
					phase_q <= phase_d; count_q <= count_d; shift_q <= shift_d;
					pay_len_q <= pay_len_d; hc_q <= hc_d; ttype_q <= ttype_d;
					tflag_q <= tflag_d; vleft_q <= vleft_d; tlen_q <= tlen_d;
					pad_q <= pad_d; err_q <= err_d; hmaj_q <= hmaj_d; hmin_q <= hmin_d;
					htype_q <= htype_d; hcorr_q <= hcorr_d;
				end
				if (it0_v) begin
					pair.first_valid <= 1'b1;
					pair.first <= it0;
					pair.second_valid <= item.end_of_frame;
					pair.second <= st_it;
				end else begin
					pair.first_valid <= item.end_of_frame;
					pair.first <= st_it;
					pair.second_valid <= 1'b0;
				end
			end else begin
				pair.first_valid <= 1'b0;
				pair.second_valid <= 1'b0;
			end
		end
	end
endmodule

>>> rtl/fhtlv_result_queue.sv
`timescale 1ns / 1ps
module fhtlv_result_queue #(
	parameter int unsigned DEPTH_LOG2 = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fhtlv_pkg::pair_t     pair,
	input  logic                 pop,
	output logic                 empty,
	output logic                 room,
	output fhtlv_pkg::out_item_t head
);
	localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

	fhtlv_pkg::out_item_t mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wp_q, rp_q;
	logic [DEPTH_LOG2:0]   cnt_q, cnt_d;
	logic                  do_pop;
	logic [1:0]            nw;

	assign empty = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign head = mem_q[rp_q];
	assign nw = 2'(pair.first_valid) + 2'(pair.second_valid);
	assign cnt_d = cnt_q + (DEPTH_LOG2+1)'(nw) - (DEPTH_LOG2+1)'(do_pop);
	// Room for two results plus the two that may already be in flight.
	assign room = cnt_q <= (DEPTH_LOG2+1)'(DEPTH - 4);

	always_ff @(posedge clk) begin
		if (pair.first_valid) mem_q[wp_q] <= pair.first;
		if (pair.second_valid) mem_q[wp_q + 1'b1] <= pair.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + DEPTH_LOG2'(nw);
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_d;
		end
	end
endmodule

>>> rtl/frame_header_tlv_checker_top.sv
`timescale 1ns / 1ps
// Frame header and TLV checker. One byte is taken per cycle when full is low;
// each byte passes one parser register stage and lands in an eight-entry result
// queue, whose storage is registered too. full rises while the queue has fewer
// than four free entries; pop drains the results in order.
module frame_header_tlv_checker_top #(
	parameter int unsigned MAX_FRAME_BYTES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  fhtlv_pkg::in_item_t  in_item,
	output logic                 empty,
	input  logic                 pop,
	output fhtlv_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	logic [31:0] magic_q;
	logic [15:0] major_q, max_minor_q, mask_q, tlow_q, thigh_q;
	fhtlv_pkg::pair_t pair;
	logic room;

	assign full = !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= 32'h5153_4750; major_q <= 16'd1; max_minor_q <= 16'd0;
			mask_q <= 16'd1; tlow_q <= 16'd1; thigh_q <= 16'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				fhtlv_pkg::REG_MAGIC:     magic_q <= cfg_data;
				fhtlv_pkg::REG_MAJOR:     major_q <= cfg_data[15:0];
				fhtlv_pkg::REG_MAX_MINOR: max_minor_q <= cfg_data[15:0];
				fhtlv_pkg::REG_FLAG_MASK: mask_q <= cfg_data[15:0];
				fhtlv_pkg::REG_TYPE_LOW:  tlow_q <= cfg_data[15:0];
				fhtlv_pkg::REG_TYPE_HIGH: thigh_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	fhtlv_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
		.clk(clk), .arst_n(arst_n), .take(push && room), .item(in_item),
		.magic_word(magic_q), .req_major(major_q), .max_minor_version(max_minor_q),
		.required_flag_mask(mask_q), .known_type_low(tlow_q), .known_type_high(thigh_q),
		.pair(pair)
	);

	fhtlv_result_queue #(.DEPTH_LOG2(3)) u_queue (
		.clk(clk), .arst_n(arst_n), .pair(pair), .pop(pop), .empty(empty),
		.room(room), .head(out_item)
	);
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned MAX_BYTES = 65536;
	localparam int unsigned PAYLOAD_LIMIT = MAX_BYTES - fhtlv_pkg::HEAD_BYTES;
	localparam int unsigned BYTES_PER_PHASE = 150;
	localparam int NUM_PHASES = 8;

	// Parser phases of the predictor.
	typedef enum logic [1:0] {PH_HEAD, PH_TLVH, PH_VALUE, PH_PAD} phase_e;

	class frame_scoreboard;
		logic [31:0] magic;
		logic [15:0] major, max_minor, flag_mask, type_low, type_high;
		int unsigned byte_count, payload_len, head_count, value_left, pad_left, tlv_len;
		logic [63:0] shifter, head_corr;
		logic [15:0] head_major, head_minor, head_type, tlv_type, tlv_flags;
		phase_e phase;
		logic [1:0] err;
		fhtlv_pkg::out_item_t expected_q[$];
		int errors, results_seen, frames_seen;

		function new();
			magic = 32'h5153_4750;
			major = 16'd1;
			max_minor = 16'd0;
			flag_mask = 16'd1;
			type_low = 16'd1;
			type_high = 16'd64;
			errors = 0;
			results_seen = 0;
			frames_seen = 0;
			clear_frame();
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				fhtlv_pkg::REG_MAGIC: magic = d;
				fhtlv_pkg::REG_MAJOR: major = d[15:0];
				fhtlv_pkg::REG_MAX_MINOR: max_minor = d[15:0];
				fhtlv_pkg::REG_FLAG_MASK: flag_mask = d[15:0];
				fhtlv_pkg::REG_TYPE_LOW: type_low = d[15:0];
				fhtlv_pkg::REG_TYPE_HIGH: type_high = d[15:0];
				default: ;
			endcase
		endfunction

		function void clear_frame();
			byte_count = 0;
			shifter = '0;
			payload_len = 0;
			phase = PH_HEAD;
			head_count = 0;
			tlv_type = '0;
			tlv_flags = '0;
			value_left = 0;
			pad_left = 0;
			err = fhtlv_pkg::ST_OK;
			head_major = '0;
			head_minor = '0;
			head_type = '0;
			head_corr = '0;
			tlv_len = 0;
		endfunction

		function void close_tlv(int unsigned end_off);
			int unsigned pad;
			logic known, req;
			fhtlv_pkg::out_item_t r;
			pad = (4 - (tlv_len & 3)) & 3;
			known = (tlv_type >= type_low) && (tlv_type <= type_high);
			req = (tlv_flags & flag_mask) != 0;
			phase = PH_TLVH;
			if ((tlv_flags & ~flag_mask) != 0) begin
				err = fhtlv_pkg::ST_INVALID;
				return;
			end
			if (!known && req) begin
				err = fhtlv_pkg::ST_VERSION;
				return;
			end
			r = '0;
			r.item_kind = fhtlv_pkg::KIND_TLV;
			r.type_code = tlv_type;
			r.length_value = tlv_len[15:0];
			r.value_offset = 16'(end_off - tlv_len - pad);
			r.known_type = known;
			r.required_bit = req;
			expected_q.push_back(r);
		endfunction

		function void header_byte(int unsigned pos);
			logic [31:0] lo32;
			fhtlv_pkg::out_item_t r;
			lo32 = shifter[31:0];
			case (pos)
				3: if (lo32 != magic) err = fhtlv_pkg::ST_INVALID;
				5: head_major = lo32[15:0];
				7: begin
					head_minor = lo32[15:0];
					if (head_major != major || head_minor > max_minor)
						err = fhtlv_pkg::ST_VERSION;
				end
				9: head_type = lo32[15:0];
				11: if (lo32[15:0] != 0) err = fhtlv_pkg::ST_INVALID;
				15: if (lo32 != fhtlv_pkg::HEAD_BYTES) err = fhtlv_pkg::ST_INVALID;
				23: begin
					head_corr = shifter;
					if (head_corr == 0) err = fhtlv_pkg::ST_INVALID;
				end
				27: payload_len = lo32;
				31: begin
					if (lo32 != 0) err = fhtlv_pkg::ST_INVALID;
					else if (payload_len > PAYLOAD_LIMIT) err = fhtlv_pkg::ST_BOUNDS;
					else begin
						r = '0;
						r.item_kind = fhtlv_pkg::KIND_HEADER;
						r.major_ver = head_major;
						r.minor_ver = head_minor;
						r.type_code = head_type;
						r.corr_id = head_corr;
						r.length_value = payload_len[15:0];
						expected_q.push_back(r);
						phase = PH_TLVH;
						head_count = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			int unsigned pos, off;
			pos = byte_count;
			if (phase == PH_HEAD) begin
				shifter = {shifter[55:0], b};
				byte_count = pos + 1;
				header_byte(pos);
				return;
			end
			off = pos - fhtlv_pkg::HEAD_BYTES;
			if (off >= payload_len) begin
				err = fhtlv_pkg::ST_BOUNDS;
				return;
			end
			byte_count = pos + 1;
			case (phase)
				PH_TLVH: begin
					if (head_count == 0 && payload_len - off < 8) begin
						err = fhtlv_pkg::ST_BOUNDS;
						return;
					end
					shifter = {shifter[55:0], b};
					if (head_count == 1) tlv_type = shifter[15:0];
					if (head_count == 3) tlv_flags = shifter[15:0];
					if (head_count < 7) begin
						head_count++;
						return;
					end
					head_count = 0;
					tlv_len = shifter[31:0];
					pad_left = (4 - (tlv_len & 3)) & 3;
					if (longint'(tlv_len) + longint'(pad_left) >
							longint'(payload_len - (off + 1))) begin
						err = fhtlv_pkg::ST_BOUNDS;
						return;
					end
					value_left = tlv_len;
					if (value_left > 0) phase = PH_VALUE;
					else if (pad_left > 0) phase = PH_PAD;
					else close_tlv(off + 1);
				end
				PH_VALUE: begin
					value_left--;
					if (value_left == 0) begin
						if (pad_left > 0) phase = PH_PAD;
						else close_tlv(off + 1);
					end
				end
				default: begin
					if (b != 0) begin
						err = fhtlv_pkg::ST_INVALID;
						return;
					end
					pad_left = (pad_left - 1) & 3;
					if (pad_left == 0) close_tlv(off + 1);
				end
			endcase
		endfunction

		function void note_input(fhtlv_pkg::in_item_t it);
			fhtlv_pkg::out_item_t r;
			if (err == fhtlv_pkg::ST_OK) take_byte(it.data_byte);
			if (it.end_of_frame) begin
				if (err == fhtlv_pkg::ST_OK) begin
					if (byte_count < fhtlv_pkg::HEAD_BYTES) err = fhtlv_pkg::ST_INVALID;
					else if (byte_count - fhtlv_pkg::HEAD_BYTES != payload_len)
						err = fhtlv_pkg::ST_BOUNDS;
				end
				r = '0;
				r.item_kind = fhtlv_pkg::KIND_STATUS;
				r.status = err;
				r.last_result = 1'b1;
				expected_q.push_back(r);
				frames_seen++;
				clear_frame();
			end
		endfunction

		function void check_result(fhtlv_pkg::out_item_t got);
			fhtlv_pkg::out_item_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected result %h", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.item_kind !== want.item_kind || got.status !== want.status ||
					got.major_ver !== want.major_ver || got.minor_ver !== want.minor_ver ||
					got.type_code !== want.type_code ||
					got.corr_id !== want.corr_id ||
					got.length_value !== want.length_value ||
					got.value_offset !== want.value_offset ||
					got.known_type !== want.known_type ||
					got.required_bit !== want.required_bit ||
					got.last_result !== want.last_result) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result mismatch at %0t\n  expected %h\n  actual   %h",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	fhtlv_pkg::in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	fhtlv_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	frame_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int unsigned bytes_sent = 0;
	logic [7:0] frame_q[$];

	frame_header_tlv_checker_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_input(in_item);
			if (pop && !empty) sb.check_result(out_item);
		end
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] b, logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		in_item <= '{data_byte: b, end_of_frame: eof};
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic put_word(logic [31:0] w, int nbytes);
		for (int i = nbytes - 1; i >= 0; i--) frame_q.push_back(w[8*i +: 8]);
	endtask

	// Builds a header that passes under the current registers, then TLVs.
	// A payload_field of all ones means the size is taken from the TLVs.
	task automatic build_frame(int num_tlvs, logic [31:0] payload_field);
		logic [7:0] body[$];
		logic [15:0] ttype, tflags;
		int unsigned len;
		logic [63:0] corr;
		body = {};
		for (int t = 0; t < num_tlvs; t++) begin
			if ($urandom_range(3) != 0 && sb.type_low <= sb.type_high)
				ttype = 16'($urandom_range(sb.type_high, sb.type_low));
			else ttype = 16'($urandom);
			case ($urandom_range(9))
				0: tflags = 16'($urandom);
				1, 2, 3: tflags = '0;
				default: tflags = 16'($urandom) & sb.flag_mask;
			endcase
			len = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(9);
			for (int i = 1; i >= 0; i--) body.push_back(ttype[8*i +: 8]);
			for (int i = 1; i >= 0; i--) body.push_back(tflags[8*i +: 8]);
			for (int i = 3; i >= 0; i--) body.push_back(8'(len >> (8*i)));
			repeat (len) body.push_back(8'($urandom));
			repeat ((4 - (len & 3)) & 3) body.push_back(8'h00);
		end
		do corr = {$urandom, $urandom}; while (corr == 0);
		frame_q = {};
		put_word(sb.magic, 4);
		put_word({16'h0, sb.major}, 2);
		put_word($urandom_range(sb.max_minor), 2);
		put_word($urandom, 2);
		put_word(0, 2);
		put_word(fhtlv_pkg::HEAD_BYTES, 4);
		put_word(corr[63:32], 4);
		put_word(corr[31:0], 4);
		put_word((payload_field == '1) ? body.size() : payload_field, 4);
		put_word(0, 4);
		foreach (body[i]) frame_q.push_back(body[i]);
	endtask

	// Mostly well-formed frames; the rest are damaged, cut, padded or pure noise.
	task automatic random_frame();
		int k;
		build_frame($urandom_range(4), '1);
		case ($urandom_range(19))
			0, 1, 2: begin
				k = $urandom_range(frame_q.size() - 1);
				frame_q[k] = frame_q[k] ^ 8'($urandom_range(255, 1));
			end
			3: repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom));
			4: begin
				k = $urandom_range(frame_q.size() - 1);
				while (frame_q.size() > k + 1) void'(frame_q.pop_back());
			end
			5: begin
				frame_q = {};
				repeat ($urandom_range(50, 1)) frame_q.push_back(8'($urandom));
			end
			6: frame_q[$urandom_range(31, 24)] = 8'($urandom);
			default: ;
		endcase
		send_frame();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under reset registers: a one-byte frame, a header whose
		// last byte ends the frame, two oversized payloads, a known TLV, a required
		// unknown TLV, bad flag bits, a nonzero pad byte and a short payload.
		frame_q = {8'hFF};
		send_frame();
		build_frame(0, 0);
		send_frame();
		build_frame(0, PAYLOAD_LIMIT + 1);
		send_frame();
		build_frame(0, 32'hFFFF_FFFF - 1);
		send_frame();
		frame_q = {};
		build_frame(0, 12);
		put_word(32'h0040_0001, 4);
		put_word(3, 4);
		put_word(32'hAABB_CC00, 4);
		send_frame();
		build_frame(0, 8);
		put_word(32'h0000_0001, 4);
		put_word(0, 4);
		send_frame();
		build_frame(0, 8);
		put_word(32'h0001_0002, 4);
		put_word(0, 4);
		send_frame();
		build_frame(0, 12);
		put_word(32'h0002_0000, 4);
		put_word(1, 4);
		put_word(32'h5500_0100, 4);
		send_frame();
		build_frame(0, 20);
		put_word(32'h0002_0000, 4);
		send_frame();

		for (int p = 0; p < NUM_PHASES; p++) begin
			push <= 1'b0;
			drain();
			case (p)
				1: begin
					write_reg(fhtlv_pkg::REG_MAGIC, 32'hFFFF_FFFF);
					write_reg(fhtlv_pkg::REG_MAJOR, 32'hFFFF);
					write_reg(fhtlv_pkg::REG_MAX_MINOR, 32'hFFFF);
					write_reg(fhtlv_pkg::REG_FLAG_MASK, 32'hFFFF);
					write_reg(fhtlv_pkg::REG_TYPE_LOW, 32'h0);
					write_reg(fhtlv_pkg::REG_TYPE_HIGH, 32'hFFFF);
				end
				2: begin
					write_reg(fhtlv_pkg::REG_MAGIC, 32'h0);
					write_reg(fhtlv_pkg::REG_MAJOR, 32'h0);
					write_reg(fhtlv_pkg::REG_MAX_MINOR, 32'h0);
					write_reg(fhtlv_pkg::REG_FLAG_MASK, 32'h1);
					write_reg(fhtlv_pkg::REG_TYPE_LOW, 32'h0);
					write_reg(fhtlv_pkg::REG_TYPE_HIGH, 32'h0);
				end
				3: begin
					write_reg(fhtlv_pkg::REG_FLAG_MASK, 32'h8000);
					write_reg(fhtlv_pkg::REG_TYPE_LOW, 32'd100);
					write_reg(fhtlv_pkg::REG_TYPE_HIGH, 32'd5);
				end
				0: ;
				default: begin
					write_reg(fhtlv_pkg::REG_MAGIC, $urandom);
					write_reg(fhtlv_pkg::REG_MAJOR, $urandom_range(65535));
					write_reg(fhtlv_pkg::REG_MAX_MINOR, $urandom_range(65535));
					write_reg(fhtlv_pkg::REG_FLAG_MASK, $urandom_range(65535, 1));
					write_reg(fhtlv_pkg::REG_TYPE_LOW, $urandom_range(200));
					write_reg(fhtlv_pkg::REG_TYPE_HIGH, $urandom_range(65535));
				end
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 74; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 74; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			for (int unsigned start = bytes_sent; bytes_sent - start < BYTES_PER_PHASE;) begin
				random_frame();
				// Let the result queue run dry with the sender held off, after each frame in the later half of phase 2.
				if (p == 2 && bytes_sent - start > BYTES_PER_PHASE / 2 && stall_pct != 0) begin
					push <= 1'b0;
					while (sb.expected_q.size() != 0) @(negedge clk);
					stall_pct = 50;
				end
			end
		end
		push <= 1'b0;

		for (int i = 0; i < 100000 && sb.expected_q.size() != 0; i++) @(negedge clk);
		if (sb.expected_q.size() != 0) begin
			$display("ERROR: %0d results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		repeat (10) @(negedge clk);
		$display("Sent %0d bytes in %0d frames over %0d register settings and idle mixes.",
			bytes_sent, sb.frames_seen, NUM_PHASES);
		$display("Checked %0d results, %0d mismatches.", sb.results_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/fhtlv_pkg.sv
rtl/fhtlv_parser.sv
rtl/fhtlv_result_queue.sv
rtl/frame_header_tlv_checker_top.sv
sim/tb_top.sv
